FILE: design/oatp_pkg.sv
// Shared constants, types and the arctangent table of the orbit position block.
`default_nettype none

package oatp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_WIDTH_DEF     = 16;

  // CORDIC datapath widths: x/y in Q30 with headroom, angle in 2^-22 degree
  localparam int CW = 34;
  localparam int ZW = 32;

  localparam int FULL_TURN     = 23040;
  localparam int HALF_TURN     = 11520;
  localparam int QUARTER_TURN  = 5760;
  localparam int PITCH_LIMIT   = 5696;
  localparam int YAW_OUT_LIMIT = 11520;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam int SQRT_STEPS = 16;
  localparam int RW = 31;  // radicand width
  localparam int QW = 32;  // root accumulator width

  // configuration register indexes
  localparam logic REG_RADIUS    = 1'b0;
  localparam logic REG_RADIUS_SQ = 1'b1;

  localparam logic [14:0] RADIUS_RST    = 15'd16384;
  localparam logic [29:0] RADIUS_SQ_RST = 30'd268435456;

  typedef struct packed {
    logic signed [14:0] yaw_w;
    logic signed [13:0] pitch_c;
    logic               zneg;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    cordic_vec_t yaw;
    cordic_vec_t pit;
  } cordic_pair_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] root;
  } sqrt_vec_t;

  function automatic logic signed [ZW-1:0] atan_angle(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = ZW'(188743680);
      1:  a = ZW'(111421900);
      2:  a = ZW'(58872272);
      3:  a = ZW'(29884485);
      4:  a = ZW'(15000234);
      5:  a = ZW'(7507429);
      6:  a = ZW'(3754631);
      7:  a = ZW'(1877430);
      8:  a = ZW'(938729);
      9:  a = ZW'(469366);
      10: a = ZW'(234683);
      11: a = ZW'(117342);
      12: a = ZW'(58671);
      13: a = ZW'(29335);
      14: a = ZW'(14668);
      15: a = ZW'(7334);
      16: a = ZW'(3667);
      17: a = ZW'(1833);
      18: a = ZW'(917);
      19: a = ZW'(458);
      20: a = ZW'(229);
      21: a = ZW'(115);
      22: a = ZW'(57);
      23: a = ZW'(29);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/oatp_cordic_cell.sv
// One CORDIC rotation cell, working the yaw and pitch vectors side by side.
`default_nettype none

module oatp_cordic_cell
  import oatp_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire side_t        in_side_i,
  input  wire cordic_pair_t in_pair_i,
  output logic              out_valid_o,
  output side_t             out_side_o,
  output cordic_pair_t      out_pair_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_angle(SHIFT);

  function automatic cordic_vec_t rotate(input cordic_vec_t v);
    cordic_vec_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = v.y >>> SHIFT;
    dy = v.x >>> SHIFT;
    if (!v.z[ZW-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - ATAN;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + ATAN;
    end
    return r;
  endfunction

  cordic_pair_t pair_d;

  always_comb begin
    pair_d.yaw = rotate(in_pair_i.yaw);
    pair_d.pit = rotate(in_pair_i.pit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_side_o <= in_side_i;
    out_pair_o <= pair_d;
  end

endmodule

`default_nettype wire

FILE: design/oatp_sqrt_cell.sv
// One digit step of the restoring integer square root.
`default_nettype none

module oatp_sqrt_cell
  import oatp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire side_t     in_side_i,
  input  wire sqrt_vec_t in_vec_i,
  output logic           out_valid_o,
  output side_t          out_side_o,
  output sqrt_vec_t      out_vec_o
);

  localparam logic [QW-1:0] BIT = QW'(1) << (30 - 2 * STEP);

  logic [QW-1:0] trial;
  sqrt_vec_t     vec_d;

  always_comb begin
    trial = in_vec_i.root + BIT;
    if ({1'b0, in_vec_i.rem} >= trial) begin
      vec_d.rem  = in_vec_i.rem - trial[RW-1:0];
      vec_d.root = (in_vec_i.root >> 1) + BIT;
    end else begin
      vec_d.rem  = in_vec_i.rem;
      vec_d.root = in_vec_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_side_o <= in_side_i;
    out_vec_o  <= vec_d;
  end

endmodule

`default_nettype wire

FILE: design/orbit_angles_to_position.sv
// Top level: orbit yaw/pitch to a point on a sphere, fully pipelined.
//
// Usage:
//   Pulse start with a yaw/pitch pair (signed, 1/64 degree). busy stays low:
//   the pipeline takes a new pair every cycle, so one transfer per clock.
//   Each pair gives one result, shown for exactly one cycle with done_o high,
//   after it passes stage 0, the row of CORDIC cells, the product and
//   rounding stages A..G, the 16 digit cells of the square root and the
//   output register.
//   Results leave in transfer order; the receiver cannot stall, so no stage
//   ever holds.
//   Configuration: cfg_we_i with cfg_idx_i (0 radius, 1 radius squared) and
//   cfg_data_i; write only while no result is outstanding.
//   Reset clears every valid bit and loads radius 16384, radius squared 2^28.
//   pos_z_o is the signed floor root of radius_squared - x^2 - y^2 (zero when
//   negative), negated unless the wrapped yaw lies strictly inside +/-90 deg.
`default_nettype none

module orbit_angles_to_position
  import oatp_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [16:0]          yaw_i,
  input  wire logic signed [16:0]          pitch_i,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [29:0]                 cfg_data_i,
  output logic                             done_o,
  output logic signed [POS_WIDTH-1:0]      pos_x_o,
  output logic signed [POS_WIDTH-1:0]      pos_y_o,
  output logic signed [POS_WIDTH-1:0]      pos_z_o,
  output logic signed [14:0]               yaw_wrapped_o,
  output logic signed [13:0]               pitch_clamped_o
);

  localparam int PW      = POS_WIDTH;
  localparam int DW      = 2 * POS_WIDTH + 32;
  localparam int LATENCY = CORDIC_STAGES + 25;
  localparam logic signed [47:0] LIM = 48'((64'sd1 <<< (PW - 1)) - 1);
  localparam logic signed [47:0] HALF_Q30 = 48'sd1 <<< 29;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [47:0] v);
    if (v > LIM) begin
      return LIM[PW-1:0];
    end else if (v < -LIM) begin
      return PW'(-LIM);
    end
    return v[PW-1:0];
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
    if (v > CW'(64'sd1 <<< 30)) begin
      return 32'sd1 <<< 30;
    end else if (v < -CW'(64'sd1 <<< 30)) begin
      return -(32'sd1 <<< 30);
    end
    return v[31:0];
  endfunction

  // ---------------- configuration registers
  logic [14:0] radius_q;
  logic [29:0] rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rsq_q    <= RADIUS_SQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS:    radius_q <= cfg_data_i[14:0];
        REG_RADIUS_SQ: rsq_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 0: wrap yaw once, clamp pitch
  logic signed [17:0] yaw_ext;
  logic signed [17:0] wy_d;
  logic signed [17:0] wy_q;
  side_t              s0_side_d;
  side_t              s0_side_q;
  logic               s0_valid_q;

  always_comb begin
    yaw_ext = 18'(yaw_i);
    if (yaw_ext > 18'sd11520) begin
      wy_d = yaw_ext - 18'sd23040;
    end else if (yaw_ext < -18'sd11520) begin
      wy_d = yaw_ext + 18'sd23040;
    end else begin
      wy_d = yaw_ext;
    end
    // saturate the reported angle, but test the depth sign on the full value
    if (wy_d > 18'sd11520) begin
      s0_side_d.yaw_w = 15'sd11520;
    end else if (wy_d < -18'sd11520) begin
      s0_side_d.yaw_w = -15'sd11520;
    end else begin
      s0_side_d.yaw_w = wy_d[14:0];
    end
    if (pitch_i > 17'sd5696) begin
      s0_side_d.pitch_c = 14'sd5696;
    end else if (pitch_i < -17'sd5696) begin
      s0_side_d.pitch_c = -14'sd5696;
    end else begin
      s0_side_d.pitch_c = pitch_i[13:0];
    end
    s0_side_d.zneg = !(wy_d < 18'sd5760 && wy_d > -18'sd5760);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    wy_q      <= wy_d;
    s0_side_q <= s0_side_d;
  end

  // ---------------- reduce yaw into -180..180 and fold into -90..90 for sin
  logic signed [17:0] r1;
  logic signed [17:0] r2;
  logic signed [17:0] r3;
  logic signed [17:0] r4;
  logic signed [17:0] rf;

  always_comb begin
    r1 = (wy_q >= 18'sd11520) ? wy_q - 18'sd23040 : wy_q;
    r2 = (r1 >= 18'sd11520) ? r1 - 18'sd23040 : r1;
    r3 = (r2 < -18'sd11520) ? r2 + 18'sd23040 : r2;
    r4 = (r3 < -18'sd11520) ? r3 + 18'sd23040 : r3;
    if (r4 > 18'sd5760) begin
      rf = 18'sd11520 - r4;
    end else if (r4 < -18'sd5760) begin
      rf = -18'sd11520 - r4;
    end else begin
      rf = r4;
    end
  end

  // ---------------- row of CORDIC cells
  logic         c_valid [CORDIC_STAGES+1];
  side_t        c_side  [CORDIC_STAGES+1];
  cordic_pair_t c_pair  [CORDIC_STAGES+1];

  always_comb begin
    c_valid[0]        = s0_valid_q;
    c_side[0]         = s0_side_q;
    c_pair[0].yaw.x   = CORDIC_GAIN;
    c_pair[0].yaw.y   = '0;
    c_pair[0].yaw.z   = {{(ZW-30){rf[13]}}, rf[13:0], 16'b0};
    c_pair[0].pit.x   = CORDIC_GAIN;
    c_pair[0].pit.y   = '0;
    c_pair[0].pit.z   = {{(ZW-30){s0_side_q.pitch_c[13]}}, s0_side_q.pitch_c, 16'b0};
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    oatp_cordic_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (c_valid[i]),
      .in_side_i  (c_side[i]),
      .in_pair_i  (c_pair[i]),
      .out_valid_o(c_valid[i+1]),
      .out_side_o (c_side[i+1]),
      .out_pair_o (c_pair[i+1])
    );
  end

  // ---------------- post stages A..G: products, rounding, squares, radicand
  logic               sa_valid_q, sb_valid_q, sc_valid_q, sd_valid_q;
  logic               se_valid_q, sf_valid_q, sg_valid_q;
  side_t              sa_side_q, sb_side_q, sc_side_q, sd_side_q;
  side_t              se_side_q, sf_side_q, sg_side_q;
  logic signed [31:0] sy_q, cp_q, sp_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] rsp_q;
  logic signed [63:0] prod_rnd;
  logic signed [63:0] sc_full;
  logic signed [31:0] scal_q;
  logic signed [47:0] py_rnd;
  logic signed [PW-1:0] py_c_q, py_d_q, py_e_q, py_f_q, py_g_q;
  logic signed [47:0] rsc_q;
  logic signed [47:0] px_rnd;
  logic signed [PW-1:0] px_e_q, px_f_q, px_g_q;
  logic signed [2*PW-1:0] pxx_q, pyy_q;
  logic signed [DW-1:0] dd;
  logic [RW-1:0]      rad_q;

  assign prod_rnd = prod_q + 64'(HALF_Q30);
  assign sc_full  = prod_rnd >>> 30;
  assign py_rnd   = (-rsp_q + HALF_Q30) >>> 30;
  assign px_rnd   = (rsc_q + HALF_Q30) >>> 30;
  assign dd       = DW'($signed({1'b0, rsq_q})) - DW'(pxx_q) - DW'(pyy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
      sb_valid_q <= 1'b0;
      sc_valid_q <= 1'b0;
      sd_valid_q <= 1'b0;
      se_valid_q <= 1'b0;
      sf_valid_q <= 1'b0;
      sg_valid_q <= 1'b0;
    end else begin
      sa_valid_q <= c_valid[CORDIC_STAGES];
      sb_valid_q <= sa_valid_q;
      sc_valid_q <= sb_valid_q;
      sd_valid_q <= sc_valid_q;
      se_valid_q <= sd_valid_q;
      sf_valid_q <= se_valid_q;
      sg_valid_q <= sf_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // A: clamp sin(yaw), cos(pitch) and sin(pitch) to +/-1.0
    sa_side_q <= c_side[CORDIC_STAGES];
    sy_q      <= clamp_q30(c_pair[CORDIC_STAGES].yaw.y);
    cp_q      <= clamp_q30(c_pair[CORDIC_STAGES].pit.x);
    sp_q      <= clamp_q30(c_pair[CORDIC_STAGES].pit.y);
    // B: sin(yaw)*cos(pitch) and radius*sin(pitch)
    sb_side_q <= sa_side_q;
    prod_q    <= sy_q * cp_q;
    rsp_q     <= $signed({1'b0, radius_q}) * sp_q;
    // C: round the product to Q30, finish y
    sc_side_q <= sb_side_q;
    scal_q    <= sc_full[31:0];
    py_c_q    <= sat_pos(py_rnd);
    // D: radius times the combined factor
    sd_side_q <= sc_side_q;
    rsc_q     <= $signed({1'b0, radius_q}) * scal_q;
    py_d_q    <= py_c_q;
    // E: finish x
    se_side_q <= sd_side_q;
    px_e_q    <= sat_pos(px_rnd);
    py_e_q    <= py_d_q;
    // F: squares
    sf_side_q <= se_side_q;
    pxx_q     <= (2*PW)'(px_e_q) * (2*PW)'(px_e_q);
    pyy_q     <= (2*PW)'(py_e_q) * (2*PW)'(py_e_q);
    px_f_q    <= px_e_q;
    py_f_q    <= py_e_q;
    // G: radicand, floored at zero
    sg_side_q <= sf_side_q;
    rad_q     <= dd[DW-1] ? '0 : dd[RW-1:0];
    px_g_q    <= px_f_q;
    py_g_q    <= py_f_q;
  end

  // ---------------- row of square-root digit cells
  logic      q_valid [SQRT_STEPS+1];
  side_t     q_side  [SQRT_STEPS+1];
  sqrt_vec_t q_vec   [SQRT_STEPS+1];
  logic signed [PW-1:0] px_line_q [SQRT_STEPS];
  logic signed [PW-1:0] py_line_q [SQRT_STEPS];

  always_comb begin
    q_valid[0]    = sg_valid_q;
    q_side[0]     = sg_side_q;
    q_vec[0].rem  = rad_q;
    q_vec[0].root = '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    oatp_sqrt_cell #(
      .STEP(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (q_valid[k]),
      .in_side_i  (q_side[k]),
      .in_vec_i   (q_vec[k]),
      .out_valid_o(q_valid[k+1]),
      .out_side_o (q_side[k+1]),
      .out_vec_o  (q_vec[k+1])
    );
  end

  // advance x and y alongside the root
  always_ff @(posedge clk_i) begin
    px_line_q[0] <= px_g_q;
    py_line_q[0] <= py_g_q;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      px_line_q[j] <= px_line_q[j-1];
      py_line_q[j] <= py_line_q[j-1];
    end
  end

  // ---------------- output register
  logic [QW-1:0]     root;
  logic signed [PW-1:0] pz_mag;

  always_comb begin
    root = q_vec[SQRT_STEPS].root;
    if ({16'b0, root} > 48'(LIM)) begin
      pz_mag = LIM[PW-1:0];
    end else begin
      pz_mag = root[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= q_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_o         <= px_line_q[SQRT_STEPS-1];
    pos_y_o         <= py_line_q[SQRT_STEPS-1];
    pos_z_o         <= q_side[SQRT_STEPS].zneg ? -pz_mag : pz_mag;
    yaw_wrapped_o   <= q_side[SQRT_STEPS].yaw_w;
    pitch_clamped_o <= q_side[SQRT_STEPS].pitch_c;
  end

  // ---------------- assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("result strobe missing at the pipeline latency");

  a_front_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && yaw_wrapped_o < 15'sd5760 && yaw_wrapped_o > -15'sd5760
      |-> !pos_z_o[PW-1])
    else $error("depth negative for a front-facing yaw");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_clamped_o <= 14'sd5696 && pitch_clamped_o >= -14'sd5696))
    else $error("clamped pitch out of range");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pos_x_o != {1'b1, {(PW-1){1'b0}}})
    else $error("x escaped saturation");

endmodule

`default_nettype wire

FILE: bench/oatp_checker.sv
// Checker for the orbit position block: predicts each result and compares it.
module oatp_checker
  import oatp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [16:0] yaw_i,
  input  wire logic signed [16:0] pitch_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [29:0]        cfg_data_i,
  input  wire logic               done_o,
  input  wire logic signed [15:0] pos_x_o,
  input  wire logic signed [15:0] pos_y_o,
  input  wire logic signed [15:0] pos_z_o,
  input  wire logic signed [14:0] yaw_wrapped_o,
  input  wire logic signed [13:0] pitch_clamped_o,
  output int                      fail_count,
  output int                      pending,
  output int                      seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [14:0] yw;
    logic signed [13:0] pc;
  } position_t;

  position_t   position_q[$];
  logic [14:0] radius_r;
  logic [29:0] radius_sq_r;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate(longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = ang * 65536;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = fshr(y, i); dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_angle(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_angle(i));
      end
    end
    s = clip(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    c = clip(x, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  function automatic longint floor_root(longint n);
    longint res, b;
    res = 0; b = 64'sd1 <<< 30;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >>> 1) + b;
      end else res = res >>> 1;
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic position_t predict_position(logic signed [16:0] yi,
                                                 logic signed [16:0] pi);
    longint yaw, pit, r, sy, cy, sp, cp, sc, px, py, pz, d;
    position_t p;
    yaw = yi; pit = pi;
    if (yaw > HALF_TURN) yaw -= FULL_TURN;
    if (yaw < -HALF_TURN) yaw += FULL_TURN;
    pit = clip(pit, -PITCH_LIMIT, PITCH_LIMIT);
    r = ((yaw % FULL_TURN) + FULL_TURN) % FULL_TURN;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) r = HALF_TURN - r;
    else if (r < -QUARTER_TURN) r = -HALF_TURN - r;
    rotate(r, sy, cy);
    rotate(pit, sp, cp);
    sc = fshr(sy * cp + (64'sd1 <<< 29), 30);
    px = clip(fshr(longint'(radius_r) * sc + (64'sd1 <<< 29), 30), -32767, 32767);
    py = clip(fshr(-(longint'(radius_r) * sp) + (64'sd1 <<< 29), 30), -32767, 32767);
    d = longint'(radius_sq_r) - px * px - py * py;
    if (d < 0) d = 0;
    pz = clip(floor_root(d), 0, 32767);
    if (!(yaw < QUARTER_TURN && yaw > -QUARTER_TURN)) pz = -pz;
    p.px = px[15:0]; p.py = py[15:0]; p.pz = pz[15:0];
    p.yw = 15'(clip(yaw, -YAW_OUT_LIMIT, YAW_OUT_LIMIT));
    p.pc = 14'(pit);
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, seen);
    fail_count++;
  endtask

  initial begin
    fail_count = 0; seen = 0;
  end

  assign pending = position_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    position_t w;
    if (!rst_ni) begin
      radius_r    <= RADIUS_RST;
      radius_sq_r <= RADIUS_SQ_RST;
    end else begin
      if (done_o) begin
        if (position_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          w = position_q.pop_front();
          if (pos_x_o !== w.px) report("pos_x", pos_x_o, w.px);
          if (pos_y_o !== w.py) report("pos_y", pos_y_o, w.py);
          if (pos_z_o !== w.pz) report("pos_z", pos_z_o, w.pz);
          if (yaw_wrapped_o !== w.yw) report("yaw_wrapped", yaw_wrapped_o, w.yw);
          if (pitch_clamped_o !== w.pc) report("pitch_clamped", pitch_clamped_o, w.pc);
        end
        seen++;
      end
      if (start && !busy) position_q.push_back(predict_position(yaw_i, pitch_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RADIUS) radius_r <= cfg_data_i[14:0];
        else radius_sq_r <= cfg_data_i;
      end
    end
  end
endmodule

FILE: bench/tb_top.sv
// Testbench top: drives angle pairs and register writes, gives the verdict.
module tb_top;
  import oatp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = CORDIC_STAGES_DEF + 25;
  localparam int LIMIT   = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic signed [16:0] yaw_i = '0;
  logic signed [16:0] pitch_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [29:0]        cfg_data_i = '0;
  wire                busy, done_o;
  wire signed [15:0]  pos_x_o, pos_y_o, pos_z_o;
  wire signed [14:0]  yaw_wrapped_o;
  wire signed [13:0]  pitch_clamped_o;
  int                 fail_count, pending, seen;
  int                 cycle = 0;

  orbit_angles_to_position uut (.*);
  oatp_checker chk (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run; the limit is far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("orbit_angles_to_position test failed");
      $finish;
    end
  end

  // Present one pair on the falling edge and hold it until the transfer.
  task automatic send_angles(int yaw, int pitch);
    start   <= 1'b1;
    yaw_i   <= 17'(yaw);
    pitch_i <= 17'(pitch);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Idle with start dropped for a random gap: often none, else mostly short, sometimes long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Drain every outstanding result, then wait out the pipeline before a write.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [29:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Angles mostly in range, sometimes anywhere in the 17-bit field.
  function automatic int pick_angle();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 131071) - 65536;
      1: return $urandom_range(0, 1) ? 34560 : -34560;
      2: return $urandom_range(0, 40) - 20 + 64 * ($urandom_range(0, 8) * 45 - 180);
      default: return $urandom_range(0, 69120) - 34560;
    endcase
  endfunction

  initial begin
    int rads[5];
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, wrap edges, clamp edges, depth sign edges.
    send_angles(0, 0);
    send_angles(34560, 34560);
    send_angles(-34560, -34560);
    send_angles(65535, -65536);
    send_angles(-65536, 65535);
    send_angles(11520, 5696);
    send_angles(11521, 5697);
    send_angles(-11520, -5696);
    send_angles(-11521, -5697);
    send_angles(5760, 0);
    send_angles(-5760, 0);
    send_angles(5759, 100);
    send_angles(-5759, -100);
    send_angles(23040, 0);
    send_angles(-23041, 0);
    send_angles(17280, 3000);
    send_angles(-1, -1);
    drain();

    // Radius squared below the sphere: root of a negative remainder is zero.
    write_reg(REG_RADIUS_SQ, 30'd1000);
    send_angles(2000, 1000);
    send_angles(-9000, -3000);
    drain();

    // Register settings: extremes, reset values, random; random upper data bits.
    rads = '{32767, 0, 1, 16384, 0};
    for (int ph = 0; ph < 6; ph++) begin
      int rv;
      rv = (ph < 4) ? rads[ph] : $urandom_range(0, 32767);
      write_reg(REG_RADIUS, {15'($urandom), 15'(rv)});
      write_reg(REG_RADIUS_SQ, (ph == 5) ? 30'h3FFF_FFFF : 30'(rv * rv));
      for (int k = 0; k < 250; k++) begin
        send_angles(pick_angle(), pick_angle());
        if ($urandom_range(0, 3) != 0) idle_gap();
      end
      drain();
    end

    // Random radius squared against a random radius, fully random fields.
    write_reg(REG_RADIUS, 30'($urandom));
    write_reg(REG_RADIUS_SQ, 30'($urandom));
    for (int k = 0; k < 100; k++) begin
      send_angles($urandom_range(0, 131071), $urandom_range(0, 131071));
      idle_gap();
    end
    drain();

    $display("covered %0d results over radius 0, 1, 16384, 32767 and random settings",
             seen);
    $display("angles span full 17-bit fields, wrap, clamp and depth-sign edges");
    if (fail_count == 0) begin
      $display("orbit_angles_to_position test passed");
    end else begin
      $display("orbit_angles_to_position test failed");
    end
    $finish;
  end
endmodule
